FILE: design/zrs_pkg.sv
// ----------------------------------------------------------------------------
// zrs_pkg
// Shared constants for the Zipf rank sampler.
// ----------------------------------------------------------------------------
package zrs_pkg;

	localparam int MAX_RANKS        = 4096;
	localparam int RANK_W           = 13;
	localparam int ADDR_W           = 12;
	localparam int WEIGHT_FRAC_BITS = 48;
	localparam int POW_W            = WEIGHT_FRAC_BITS + 1;
	localparam int SUM_W            = 64;
	localparam int EXP_W            = 3;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 13;
	localparam int CNT_W            = 6;

	localparam logic [EXP_W-1:0]     EXP_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_COUNT = 2'd1;

endpackage

FILE: design/zrs_div.sv
// ----------------------------------------------------------------------------
// zrs_div
// Restoring divider, one quotient bit per cycle: 2^48 / divisor.
// ----------------------------------------------------------------------------
module zrs_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [zrs_pkg::POW_W-1:0] divisor,
	output logic                     done,
	output logic [zrs_pkg::POW_W-1:0] quotient
);
	import zrs_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] bit_q;
	logic [POW_W:0]   rem_q;
	logic [POW_W-1:0] quo_q;
	logic [POW_W-1:0] dvs_q;
	logic [POW_W:0]   rem_shift;
	logic             fits;

	assign rem_shift = {rem_q[POW_W-1:0], (bit_q == CNT_W'(WEIGHT_FRAC_BITS))};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= CNT_W'(WEIGHT_FRAC_BITS);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_shift - {1'b0, dvs_q} : rem_shift;
			quo_q <= {quo_q[POW_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

FILE: design/zipf_rank_sampler_unit.sv
// ----------------------------------------------------------------------------
// zipf_rank_sampler_unit
// Zipf rank sampler by inverse CDF over a table of running weight sums.
// ----------------------------------------------------------------------------
// A word on the slave stream carries a 32-bit uniform fraction; the master
// stream returns one word per input, the sampled rank from 1 to the rank
// count, clamped to 1..4096. The exponent and rank count are set over the
// write port; the user must set them only while the block is idle, as the
// block itself does not enforce this. A write to either register marks the
// weight table as stale. The first word after reset or after a write
// rebuilds the table: for each rank the power is formed by repeated
// multiplication and the weight by a serial divider. The table holds the
// running sums in one 4096 x 64 synchronous memory. Each sample then forms
// the threshold product and runs a binary search over the table, each step
// a memory read and a compare. Reset clears the state machine and the ready
// and output valid flags and restores the register defaults. When the
// receiver stalls, the finished word waits in the output register and the
// next input word is accepted.
// ----------------------------------------------------------------------------
module zipf_rank_sampler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // [31:0] uniform_fraction
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,  // [12:0] rank
	input  logic                           cfg_we,
	input  logic [zrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [zrs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import zrs_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_POW  = 10'b0000000010,
		ST_DIVS = 10'b0000000100,
		ST_DIVW = 10'b0000001000,
		ST_PM0  = 10'b0000010000,
		ST_PM1  = 10'b0000100000,
		ST_THR  = 10'b0001000000,
		ST_SRD  = 10'b0010000000,
		ST_SCMP = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [EXP_W-1:0]    exp_q;
	logic [RANK_W-1:0]   cnt_q;
	logic                ready_q;
	logic [31:0]         z_q;
	logic [RANK_W-1:0]   idx_q;
	logic [EXP_W-1:0]    k_q;
	logic [POW_W-1:0]    pow_q;
	logic [SUM_W-1:0]    cum_q;
	logic [SUM_W-1:0]    total_q;
	logic [63:0]         plo_q;
	logic [63:0]         phi_q;
	logic [SUM_W:0]      thr_q;
	logic [RANK_W-1:0]   lo_q;
	logic [RANK_W-1:0]   hi_q;
	logic [RANK_W-1:0]   mid_q;
	logic [RANK_W-1:0]   res_q;
	logic [RANK_W-1:0]   odata_q;
	logic                ovalid_q;

	logic [EXP_W-1:0]    alpha;
	logic [RANK_W-1:0]   n_eff;
	logic [SUM_W-1:0]    cum_next;
	logic [95:0]         rhs;
	logic [RANK_W:0]     mid_sum;
	logic [RANK_W-1:0]   mid;
	logic [POW_W+RANK_W-1:0] pow_prod;

	logic                div_start;
	logic                div_done;
	logic [POW_W-1:0]    div_quo;

	logic [SUM_W-1:0]    mem [MAX_RANKS];
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [ADDR_W-1:0]   mem_raddr;
	logic                mem_re;
	logic [SUM_W-1:0]    mem_rdata;

	zrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (pow_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign alpha    = (exp_q > EXP_MAX) ? EXP_MAX : exp_q;
	assign n_eff    = (cnt_q == '0) ? RANK_W'(1) :
	                  (cnt_q > RANK_W'(MAX_RANKS)) ? RANK_W'(MAX_RANKS) : cnt_q;
	assign cum_next = cum_q + SUM_W'(div_quo);
	assign rhs      = {phi_q, 32'd0} + {32'd0, plo_q};
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[RANK_W:1];
	assign pow_prod = pow_q * idx_q;

	assign div_start = (state_q == ST_DIVS);
	assign mem_we    = (state_q == ST_DIVW) && div_done;
	assign mem_waddr = ADDR_W'(idx_q - 1'b1);
	assign mem_re    = (state_q == ST_SRD) && (lo_q != hi_q);
	assign mem_raddr = ADDR_W'(mid - 1'b1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= cum_next;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {3'd0, odata_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			exp_q    <= 3'd1;
			cnt_q    <= 13'd1024;
			ready_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_axis_tready && (state_q != ST_OUT)) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == REG_EXPONENT) begin
					exp_q   <= cfg_data[EXP_W-1:0];
					ready_q <= 1'b0;
				end else if (cfg_index == REG_RANK_COUNT) begin
					cnt_q   <= cfg_data;
					ready_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ready_q ? ST_PM0 : ST_POW;
					end
				end
				ST_POW: begin
					if (k_q == alpha) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						if (idx_q == n_eff) begin
							ready_q <= 1'b1;
							state_q <= ST_PM0;
						end else begin
							state_q <= ST_POW;
						end
					end
				end
				ST_PM0: state_q <= ST_PM1;
				ST_PM1: state_q <= ST_THR;
				ST_THR: state_q <= ST_SRD;
				ST_SRD: begin
					if (lo_q == hi_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: state_q <= ST_SRD;
				ST_OUT: begin
					if (!ovalid_q || m_axis_tready) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				z_q   <= (s_axis_tdata == 32'd0) ? 32'd1 : s_axis_tdata;
				idx_q <= RANK_W'(1);
				k_q   <= '0;
				pow_q <= POW_W'(1);
				cum_q <= '0;
			end
			ST_POW: begin
				if (k_q != alpha) begin
					pow_q <= pow_prod[POW_W-1:0];
					k_q   <= k_q + 1'b1;
				end
			end
			ST_DIVS: begin
			end
			ST_DIVW: begin
				if (div_done) begin
					cum_q   <= cum_next;
					total_q <= cum_next;
					idx_q   <= idx_q + 1'b1;
					k_q     <= '0;
					pow_q   <= POW_W'(1);
				end
			end
			ST_PM0: plo_q <= z_q * total_q[31:0];
			ST_PM1: phi_q <= z_q * total_q[63:32];
			ST_THR: begin
				thr_q <= {1'b0, rhs[95:32]} + {{SUM_W{1'b0}}, (rhs[31:0] != 32'd0)};
				lo_q  <= RANK_W'(1);
				hi_q  <= n_eff;
			end
			ST_SRD: begin
				mid_q <= mid;
				res_q <= lo_q;
			end
			ST_SCMP: begin
				if ({1'b0, mem_rdata} >= thr_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!ovalid_q || m_axis_tready) begin
					odata_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
